[src/dependence_distance_alu_core_defines.svh]
// Assertion macros for the dependence-distance ALU.
`ifndef DEPENDENCE_DISTANCE_ALU_CORE_DEFINES_SVH
`define DEPENDENCE_DISTANCE_ALU_CORE_DEFINES_SVH

`ifndef SYNTH

`define DDA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dda assertion failed");

`define DDA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dda assertion failed");

`else

`define DDA_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define DDA_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[src/dda_pkg.sv]
// Shared types and codes for the dependence-distance ALU.
package dda_pkg;

    localparam int DIST_BITS_DEF = 16;

    typedef logic [3:0] op_t;
    typedef logic [1:0] kind_t;
    typedef logic [1:0] truth_t;

    localparam op_t OP_ADD = 4'd0;
    localparam op_t OP_SUB = 4'd1;
    localparam op_t OP_MUL = 4'd2;
    localparam op_t OP_NEG = 4'd3;
    localparam op_t OP_GT  = 4'd4;
    localparam op_t OP_GE  = 4'd5;
    localparam op_t OP_LT  = 4'd6;
    localparam op_t OP_LE  = 4'd7;
    localparam op_t OP_EQ  = 4'd8;
    localparam op_t OP_NE  = 4'd9;

    localparam kind_t K_EXACT   = 2'd0;
    localparam kind_t K_ATLEAST = 2'd1;
    localparam kind_t K_ATMOST  = 2'd2;
    localparam kind_t K_UNKNOWN = 2'd3;

    localparam truth_t T_FALSE = 2'd0;
    localparam truth_t T_TRUE  = 2'd1;
    localparam truth_t T_UNDET = 2'd2;

    typedef struct packed {
        op_t   op;
        kind_t a_kind;
        kind_t b_kind;
    } cmp_ctl_t;

endpackage

[src/dda_cmp.sv]
// Three-valued comparison of two dependence elements.
module dda_cmp #(
    parameter int DIST_BITS = dda_pkg::DIST_BITS_DEF
) (
    input  dda_pkg::cmp_ctl_t              ctl,
    input  logic signed [DIST_BITS-1:0]    a_dist,
    input  logic signed [DIST_BITS-1:0]    b_dist,
    output dda_pkg::truth_t                truth
);

    // x is exact, y is whatever it is
    function automatic dda_pkg::truth_t gt_exact_first(
        input logic signed [DIST_BITS-1:0] xv,
        input dda_pkg::kind_t               yk,
        input logic signed [DIST_BITS-1:0] yv
    );
        dda_pkg::truth_t r;
        r = dda_pkg::T_UNDET;
        if (xv > 0) begin
            if (yk == dda_pkg::K_ATMOST)
                r = dda_pkg::T_TRUE;
            else if (yk == dda_pkg::K_ATLEAST && xv < yv)
                r = dda_pkg::T_FALSE;
        end else if (xv == 0) begin
            if (yk == dda_pkg::K_ATMOST && yv < 0)
                r = dda_pkg::T_TRUE;
            else if (yk == dda_pkg::K_ATLEAST && yv > 0)
                r = dda_pkg::T_FALSE;
        end else begin
            if (yk == dda_pkg::K_ATLEAST)
                r = dda_pkg::T_FALSE;
            else if (yk == dda_pkg::K_ATMOST && xv > yv)
                r = dda_pkg::T_TRUE;
        end
        return r;
    endfunction

    function automatic dda_pkg::truth_t gt_el(
        input dda_pkg::kind_t               xk,
        input logic signed [DIST_BITS-1:0] xv,
        input dda_pkg::kind_t               yk,
        input logic signed [DIST_BITS-1:0] yv
    );
        dda_pkg::truth_t r;
        dda_pkg::truth_t s;
        r = dda_pkg::T_UNDET;
        s = gt_exact_first(yv, xk, xv);
        if (xk == dda_pkg::K_EXACT && yk == dda_pkg::K_EXACT)
            r = (xv > yv) ? dda_pkg::T_TRUE : dda_pkg::T_FALSE;
        else if (xk == dda_pkg::K_EXACT)
            r = gt_exact_first(xv, yk, yv);
        else if (yk == dda_pkg::K_EXACT) begin
            if (s == dda_pkg::T_TRUE)
                r = dda_pkg::T_FALSE;
            else if (s == dda_pkg::T_FALSE)
                r = dda_pkg::T_TRUE;
            else
                r = s;
        end else if (xk == dda_pkg::K_ATLEAST && yk == dda_pkg::K_ATMOST && xv > yv)
            r = dda_pkg::T_TRUE;
        else if (xk == dda_pkg::K_ATMOST && yk == dda_pkg::K_ATLEAST && xv < yv)
            r = dda_pkg::T_FALSE;
        return r;
    endfunction

    logic            is_eq;
    dda_pkg::truth_t gt_ab;
    dda_pkg::truth_t gt_ba;

    assign is_eq = (ctl.a_kind == dda_pkg::K_UNKNOWN && ctl.b_kind == dda_pkg::K_UNKNOWN)
                 || (ctl.a_kind == ctl.b_kind && a_dist == b_dist);
    assign gt_ab = gt_el(ctl.a_kind, a_dist, ctl.b_kind, b_dist);
    assign gt_ba = gt_el(ctl.b_kind, b_dist, ctl.a_kind, a_dist);

    always_comb begin
        case (ctl.op) inside
            dda_pkg::OP_ADD, dda_pkg::OP_SUB, dda_pkg::OP_MUL, dda_pkg::OP_NEG:
                truth = dda_pkg::T_FALSE;
            dda_pkg::OP_GT: truth = gt_ab;
            dda_pkg::OP_GE: truth = is_eq ? dda_pkg::T_TRUE : gt_ab;
            dda_pkg::OP_LT: truth = gt_ba;
            dda_pkg::OP_LE: truth = is_eq ? dda_pkg::T_TRUE : gt_ba;
            dda_pkg::OP_EQ: truth = is_eq ? dda_pkg::T_TRUE : dda_pkg::T_FALSE;
            dda_pkg::OP_NE: truth = is_eq ? dda_pkg::T_FALSE : dda_pkg::T_TRUE;
            default:        truth = dda_pkg::T_UNDET;
        endcase
    end

endmodule

[src/dependence_distance_alu_core.sv]
// Dependence-distance ALU: three-stage pipelined element arithmetic and compare.
//
// Input stream (s_*): one beat carries an operation and two dependence elements
// (kind plus signed distance). Output stream (m_*): one beat per input beat, in
// order, carrying the result element, a three-valued truth and an overflow flag.
// Arithmetic ops return the element with truth false; compares return kind
// unknown, distance zero. Distances out of range saturate and set overflow.
//
// Stages: operand prep, then add/multiply and compare, then saturation into the
// output register.
// Throughput: one beat per cycle while m_tready holds; the single multiplier
// in stage two is fully pipelined with the rest.
// Each stage holds its beat while the stage after it is full and not moving, so
// a stall on m_tready back-fills the pipe and then drops s_tready; nothing is
// lost or repeated. Reset (aresetn low, synchronous) empties all stages.
`include "dependence_distance_alu_core_defines.svh"

module dependence_distance_alu_core #(
    parameter  int DIST_BITS = dda_pkg::DIST_BITS_DEF,
    localparam int IN_BITS   = 8 + 2 * DIST_BITS,
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = 5 + DIST_BITS,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // operation, a_kind, a_dist, b_kind, b_dist (lowest first), zero padded
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // res_kind, res_dist, truth, overflow (lowest first), zero padded
    output logic [OUT_W-1:0] m_tdata
);

    localparam int D  = DIST_BITS;
    localparam int SW = D + 2;
    localparam int PW = 2 * D;

    localparam logic signed [PW-1:0] WMAX = {{(PW-D+1){1'b0}}, {(D-1){1'b1}}};
    localparam logic signed [PW-1:0] WMIN = {{(PW-D+1){1'b1}}, {(D-1){1'b0}}};

    function automatic dda_pkg::kind_t neg_kind(input dda_pkg::kind_t k);
        dda_pkg::kind_t r;
        unique case (k)
            dda_pkg::K_ATLEAST: r = dda_pkg::K_ATMOST;
            dda_pkg::K_ATMOST:  r = dda_pkg::K_ATLEAST;
            default:            r = k;
        endcase
        return r;
    endfunction

    function automatic dda_pkg::kind_t add_kind(
        input dda_pkg::kind_t ka,
        input dda_pkg::kind_t kb,
        input logic           s_pos,
        input logic           s_neg
    );
        dda_pkg::kind_t k;
        if (ka == dda_pkg::K_EXACT || kb == dda_pkg::K_EXACT) begin
            k = (ka == dda_pkg::K_EXACT) ? kb : ka;
            if ((s_pos && k == dda_pkg::K_ATMOST) || (s_neg && k == dda_pkg::K_ATLEAST))
                k = dda_pkg::K_UNKNOWN;
        end else if (ka == dda_pkg::K_UNKNOWN || ka != kb) begin
            k = dda_pkg::K_UNKNOWN;
        end else begin
            k = ka;
        end
        return k;
    endfunction

    // exact factor with sign (pos/zero) against the other factor's kind
    function automatic dda_pkg::kind_t mul_exact_kind(
        input logic           pos,
        input logic           zero,
        input dda_pkg::kind_t ko
    );
        dda_pkg::kind_t k;
        unique case (ko)
            dda_pkg::K_EXACT:   k = dda_pkg::K_EXACT;
            dda_pkg::K_ATLEAST: k = pos ? dda_pkg::K_ATLEAST
                                  : (zero ? dda_pkg::K_EXACT : dda_pkg::K_ATMOST);
            dda_pkg::K_ATMOST:  k = pos ? dda_pkg::K_ATMOST
                                  : (zero ? dda_pkg::K_EXACT : dda_pkg::K_ATLEAST);
            default:            k = zero ? dda_pkg::K_EXACT : dda_pkg::K_UNKNOWN;
        endcase
        return k;
    endfunction

    // ---- stage 1: unpack, negate operands ----
    dda_pkg::op_t          in_op;
    dda_pkg::kind_t        in_ak;
    dda_pkg::kind_t        in_bk;
    logic signed [D-1:0]   in_av;
    logic signed [D-1:0]   in_bv;
    logic signed [D:0]     in_b_ext;
    logic signed [D:0]     in_a_neg;
    logic signed [D:0]     in_b_neg;
    dda_pkg::kind_t        in_addk;
    logic signed [D:0]     in_addv;

    assign in_op    = s_tdata[3:0];
    assign in_ak    = s_tdata[5:4];
    assign in_av    = s_tdata[6+D-1:6];
    assign in_bk    = s_tdata[6+D+1:6+D];
    assign in_bv    = s_tdata[8+2*D-1:8+D];
    assign in_b_ext = {in_bv[D-1], in_bv};
    assign in_a_neg = -{in_av[D-1], in_av};
    assign in_b_neg = -in_b_ext;
    assign in_addk  = (in_op == dda_pkg::OP_SUB) ? neg_kind(in_bk) : in_bk;
    assign in_addv  = (in_op == dda_pkg::OP_SUB) ? in_b_neg : in_b_ext;

    logic                v1_reg, v1_next;
    logic                v2_reg, v2_next;
    logic                v3_reg, v3_next;
    logic                rdy1, rdy2, rdy3;

    dda_pkg::op_t        op1_reg;
    dda_pkg::kind_t      ak1_reg, bk1_reg, addk1_reg, negk1_reg;
    logic signed [D-1:0] av1_reg, bv1_reg;
    logic signed [D:0]   addv1_reg, negv1_reg;

    dda_pkg::kind_t      kind2_reg, kind2_next;
    logic signed [PW-1:0] wide2_reg, wide2_next;
    dda_pkg::truth_t     truth2_reg, truth2_next;

    dda_pkg::kind_t      kind3_reg, kind3_next;
    logic signed [D-1:0] dist3_reg, dist3_next;
    dda_pkg::truth_t     truth3_reg;
    logic                ovf3_reg, ovf3_next;

    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign v1_next = rdy1 ? s_tvalid : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && rdy1) begin
            op1_reg   <= in_op;
            ak1_reg   <= in_ak;
            av1_reg   <= in_av;
            bk1_reg   <= in_bk;
            bv1_reg   <= in_bv;
            addk1_reg <= in_addk;
            addv1_reg <= in_addv;
            negk1_reg <= neg_kind(in_ak);
            negv1_reg <= in_a_neg;
        end
    end

    // ---- stage 2: add, multiply, compare ----
    logic signed [SW-1:0] sum;
    logic signed [PW-1:0] a_wide, b_wide, prod;
    logic                 s_pos, s_neg;
    logic                 a_pos, a_zero, b_pos, b_zero;
    dda_pkg::kind_t       mul_k;
    dda_pkg::cmp_ctl_t    cmp_ctl;

    assign sum    = {{2{av1_reg[D-1]}}, av1_reg} + {addv1_reg[D], addv1_reg};
    assign a_wide = {{D{av1_reg[D-1]}}, av1_reg};
    assign b_wide = {{D{bv1_reg[D-1]}}, bv1_reg};
    assign prod   = a_wide * b_wide;
    assign s_neg  = sum[SW-1];
    assign s_pos  = !sum[SW-1] && (|sum);
    assign a_zero = (av1_reg == '0);
    assign a_pos  = !av1_reg[D-1] && !a_zero;
    assign b_zero = (bv1_reg == '0);
    assign b_pos  = !bv1_reg[D-1] && !b_zero;

    always_comb begin
        if (ak1_reg == dda_pkg::K_EXACT)
            mul_k = mul_exact_kind(a_pos, a_zero, bk1_reg);
        else if (ak1_reg == dda_pkg::K_UNKNOWN || bk1_reg == dda_pkg::K_UNKNOWN)
            mul_k = dda_pkg::K_UNKNOWN;
        else if (bk1_reg == dda_pkg::K_EXACT)
            mul_k = mul_exact_kind(b_pos, b_zero, ak1_reg);
        else if (ak1_reg == bk1_reg)
            mul_k = dda_pkg::K_ATLEAST;
        else
            mul_k = dda_pkg::K_ATMOST;
    end

    always_comb begin
        case (op1_reg) inside
            dda_pkg::OP_ADD, dda_pkg::OP_SUB: begin
                kind2_next = add_kind(ak1_reg, addk1_reg, s_pos, s_neg);
                wide2_next = {{(PW-SW){sum[SW-1]}}, sum};
            end
            dda_pkg::OP_MUL: begin
                kind2_next = mul_k;
                wide2_next = prod;
            end
            dda_pkg::OP_NEG: begin
                kind2_next = negk1_reg;
                wide2_next = {{(PW-D-1){negv1_reg[D]}}, negv1_reg};
            end
            default: begin
                kind2_next = dda_pkg::K_UNKNOWN;
                wide2_next = '0;
            end
        endcase
    end

    assign cmp_ctl.op     = op1_reg;
    assign cmp_ctl.a_kind = ak1_reg;
    assign cmp_ctl.b_kind = bk1_reg;

    dda_cmp #(
        .DIST_BITS (DIST_BITS)
    ) u_cmp (
        .ctl    (cmp_ctl),
        .a_dist (av1_reg),
        .b_dist (bv1_reg),
        .truth  (truth2_next)
    );

    always_ff @(posedge aclk) begin
        if (v1_reg && rdy2) begin
            kind2_reg  <= kind2_next;
            wide2_reg  <= wide2_next;
            truth2_reg <= truth2_next;
        end
    end

    // ---- stage 3: saturate into the output register ----
    always_comb begin
        kind3_next = kind2_reg;
        dist3_next = wide2_reg[D-1:0];
        ovf3_next  = 1'b0;
        if (kind2_reg == dda_pkg::K_UNKNOWN) begin
            dist3_next = '0;
        end else if (wide2_reg > WMAX) begin
            dist3_next = WMAX[D-1:0];
            ovf3_next  = 1'b1;
        end else if (wide2_reg < WMIN) begin
            dist3_next = WMIN[D-1:0];
            ovf3_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (v2_reg && rdy3) begin
            kind3_reg  <= kind3_next;
            dist3_reg  <= dist3_next;
            truth3_reg <= truth2_reg;
            ovf3_reg   <= ovf3_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, ovf3_reg, truth3_reg, dist3_reg, kind3_reg};

    // unknown results carry no distance
    `DDA_ASSERT_IMP(a_unknown_zero, aclk, aresetn,
        v3_reg && kind3_reg == dda_pkg::K_UNKNOWN, dist3_reg == '0 && !ovf3_reg)
    // saturation only pins to the ends of the range
    `DDA_ASSERT_IMP(a_ovf_at_end, aclk, aresetn,
        v3_reg && ovf3_reg, dist3_reg == WMAX[D-1:0] || dist3_reg == WMIN[D-1:0])
    // overflow only on arithmetic results
    `DDA_ASSERT_IMP(a_ovf_arith, aclk, aresetn,
        v3_reg && ovf3_reg, truth3_reg == dda_pkg::T_FALSE && kind3_reg != dda_pkg::K_UNKNOWN)
    // a beat held behind a stalled output stage is not dropped
    `DDA_ASSERT_NXT(a_s2_hold, aclk, aresetn,
        v2_reg && v3_reg && !m_tready, v2_reg)

endmodule

[verif/dependence_distance_alu_core_test.sv]
// Self-checking stream testbench for the dependence-distance ALU core.
`timescale 1ns / 1ps

module dependence_distance_alu_core_test;

    localparam int     DW         = dda_pkg::DIST_BITS_DEF;
    localparam int     IN_W       = ((8 + 2 * DW + 7) / 8) * 8;
    localparam int     OUT_W      = ((5 + DW + 7) / 8) * 8;
    localparam longint DIST_MAX   = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint DIST_MIN   = -DIST_MAX - 1;
    localparam int     CYCLE_CAP  = 200000;
    localparam int     DRAIN_WAIT = 12;

    typedef struct {
        dda_pkg::kind_t kind;
        longint         dval;
    } dep_elem_t;

    typedef struct {
        dda_pkg::kind_t  kind;
        logic [DW-1:0]   dval;
        dda_pkg::truth_t truth;
        logic            ovf;
    } alu_result_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    // operation, a_kind, a_dist, b_kind, b_dist (lowest first), zero padded
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    // res_kind, res_dist, truth, overflow (lowest first), zero padded
    logic [OUT_W-1:0] m_tdata;

    alu_result_t pending_results[$];
    int          error_count;
    int          cycle_count;
    int          src_idle_pct;
    int          sink_stall_pct;

    dependence_distance_alu_core #(.DIST_BITS(DW)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic dep_elem_t make_elem(dda_pkg::kind_t k, longint d);
        dep_elem_t e;
        e.kind = k;
        e.dval = (k == dda_pkg::K_UNKNOWN) ? 0 : d;
        return e;
    endfunction

    function automatic dep_elem_t elem_sum(dep_elem_t a, dep_elem_t b);
        longint         s;
        dda_pkg::kind_t k;
        s = a.dval + b.dval;
        if (a.kind == dda_pkg::K_EXACT || b.kind == dda_pkg::K_EXACT) begin
            k = (a.kind == dda_pkg::K_EXACT) ? b.kind : a.kind;
            // a bound pushed across zero the wrong way says nothing
            if ((s > 0 && k == dda_pkg::K_ATMOST) || (s < 0 && k == dda_pkg::K_ATLEAST))
                return make_elem(dda_pkg::K_UNKNOWN, 0);
            return make_elem(k, s);
        end
        if (a.kind == dda_pkg::K_UNKNOWN || b.kind == dda_pkg::K_UNKNOWN || a.kind != b.kind)
            return make_elem(dda_pkg::K_UNKNOWN, 0);
        return make_elem(a.kind, s);
    endfunction

    function automatic dep_elem_t elem_negate(dep_elem_t a);
        case (a.kind)
            dda_pkg::K_EXACT:   return make_elem(dda_pkg::K_EXACT, -a.dval);
            dda_pkg::K_ATLEAST: return make_elem(dda_pkg::K_ATMOST, -a.dval);
            dda_pkg::K_ATMOST:  return make_elem(dda_pkg::K_ATLEAST, -a.dval);
            default:            return make_elem(dda_pkg::K_UNKNOWN, 0);
        endcase
    endfunction

    // x is exact; the sign of its distance decides the direction of the bound
    function automatic dep_elem_t scale_by_exact(dep_elem_t x, dep_elem_t y);
        longint p;
        p = x.dval * y.dval;
        case (y.kind)
            dda_pkg::K_EXACT: return make_elem(dda_pkg::K_EXACT, p);
            dda_pkg::K_ATLEAST: begin
                if (x.dval > 0) return make_elem(dda_pkg::K_ATLEAST, p);
                if (x.dval == 0) return make_elem(dda_pkg::K_EXACT, p);
                return make_elem(dda_pkg::K_ATMOST, p);
            end
            dda_pkg::K_ATMOST: begin
                if (x.dval > 0) return make_elem(dda_pkg::K_ATMOST, p);
                if (x.dval == 0) return make_elem(dda_pkg::K_EXACT, p);
                return make_elem(dda_pkg::K_ATLEAST, p);
            end
            default: return (x.dval == 0) ? make_elem(dda_pkg::K_EXACT, 0)
                                          : make_elem(dda_pkg::K_UNKNOWN, 0);
        endcase
    endfunction

    function automatic dep_elem_t elem_product(dep_elem_t a, dep_elem_t b);
        if (a.kind == dda_pkg::K_EXACT) return scale_by_exact(a, b);
        if (a.kind == dda_pkg::K_UNKNOWN || b.kind == dda_pkg::K_UNKNOWN)
            return make_elem(dda_pkg::K_UNKNOWN, 0);
        if (b.kind == dda_pkg::K_EXACT) return scale_by_exact(b, a);
        if (a.kind == b.kind) return make_elem(dda_pkg::K_ATLEAST, a.dval * b.dval);
        return make_elem(dda_pkg::K_ATMOST, a.dval * b.dval);
    endfunction

    function automatic bit elem_equal(dep_elem_t a, dep_elem_t b);
        if (a.kind == dda_pkg::K_UNKNOWN && b.kind == dda_pkg::K_UNKNOWN) return 1'b1;
        return a.kind == b.kind && a.dval == b.dval;
    endfunction

    function automatic dda_pkg::truth_t exact_above_bound(dep_elem_t x, dep_elem_t y);
        if (x.dval > 0) begin
            if (y.kind == dda_pkg::K_ATMOST) return dda_pkg::T_TRUE;
            if (y.kind == dda_pkg::K_ATLEAST && x.dval < y.dval) return dda_pkg::T_FALSE;
        end else if (x.dval == 0) begin
            if (y.kind == dda_pkg::K_ATMOST && y.dval < 0) return dda_pkg::T_TRUE;
            if (y.kind == dda_pkg::K_ATLEAST && y.dval > 0) return dda_pkg::T_FALSE;
        end else begin
            if (y.kind == dda_pkg::K_ATLEAST) return dda_pkg::T_FALSE;
            if (y.kind == dda_pkg::K_ATMOST && x.dval > y.dval) return dda_pkg::T_TRUE;
        end
        return dda_pkg::T_UNDET;
    endfunction

    function automatic dda_pkg::truth_t elem_greater(dep_elem_t a, dep_elem_t b);
        dda_pkg::truth_t t;
        if (a.kind == dda_pkg::K_EXACT && b.kind == dda_pkg::K_EXACT)
            return (a.dval > b.dval) ? dda_pkg::T_TRUE : dda_pkg::T_FALSE;
        if (a.kind == dda_pkg::K_EXACT) return exact_above_bound(a, b);
        if (b.kind == dda_pkg::K_EXACT) begin
            t = exact_above_bound(b, a);
            if (t == dda_pkg::T_TRUE) return dda_pkg::T_FALSE;
            if (t == dda_pkg::T_FALSE) return dda_pkg::T_TRUE;
            return t;
        end
        if (a.kind == dda_pkg::K_ATLEAST && b.kind == dda_pkg::K_ATMOST && a.dval > b.dval)
            return dda_pkg::T_TRUE;
        if (a.kind == dda_pkg::K_ATMOST && b.kind == dda_pkg::K_ATLEAST && a.dval < b.dval)
            return dda_pkg::T_FALSE;
        return dda_pkg::T_UNDET;
    endfunction

    function automatic alu_result_t predict_result(dda_pkg::op_t op, dda_pkg::kind_t ak,
                                                   logic signed [DW-1:0] ad,
                                                   dda_pkg::kind_t bk,
                                                   logic signed [DW-1:0] bd);
        dep_elem_t   a;
        dep_elem_t   b;
        dep_elem_t   r;
        alu_result_t res;
        bit          arith;
        // operands keep their raw distance even when the kind is unknown
        a.kind = ak;
        a.dval = longint'(ad);
        b.kind = bk;
        b.dval = longint'(bd);
        r = make_elem(dda_pkg::K_UNKNOWN, 0);
        arith = 1'b1;
        res.truth = dda_pkg::T_FALSE;
        case (op)
            dda_pkg::OP_ADD: r = elem_sum(a, b);
            dda_pkg::OP_SUB: r = elem_sum(a, elem_negate(b));
            dda_pkg::OP_MUL: r = elem_product(a, b);
            dda_pkg::OP_NEG: r = elem_negate(a);
            dda_pkg::OP_GT: begin
                arith = 1'b0;
                res.truth = elem_greater(a, b);
            end
            dda_pkg::OP_GE: begin
                arith = 1'b0;
                res.truth = elem_equal(a, b) ? dda_pkg::T_TRUE : elem_greater(a, b);
            end
            dda_pkg::OP_LT: begin
                arith = 1'b0;
                res.truth = elem_greater(b, a);
            end
            dda_pkg::OP_LE: begin
                arith = 1'b0;
                res.truth = elem_equal(a, b) ? dda_pkg::T_TRUE : elem_greater(b, a);
            end
            dda_pkg::OP_EQ: begin
                arith = 1'b0;
                res.truth = elem_equal(a, b) ? dda_pkg::T_TRUE : dda_pkg::T_FALSE;
            end
            dda_pkg::OP_NE: begin
                arith = 1'b0;
                res.truth = elem_equal(a, b) ? dda_pkg::T_FALSE : dda_pkg::T_TRUE;
            end
            default: begin
                arith = 1'b0;
                res.truth = dda_pkg::T_UNDET;
            end
        endcase
        res.ovf = 1'b0;
        if (arith && r.kind != dda_pkg::K_UNKNOWN) begin
            if (r.dval > DIST_MAX) begin
                r.dval = DIST_MAX;
                res.ovf = 1'b1;
            end else if (r.dval < DIST_MIN) begin
                r.dval = DIST_MIN;
                res.ovf = 1'b1;
            end
        end
        res.kind = r.kind;
        res.dval = r.dval[DW-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------ stream driving

    task automatic send_item(dda_pkg::op_t op, dda_pkg::kind_t ak, logic [DW-1:0] ad,
                             dda_pkg::kind_t bk, logic [DW-1:0] bd);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({bd, bk, ad, ak, op});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_result(op, ak, ad, bk, bd));
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        alu_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing outstanding, data %h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.kind) begin
                    $display("%0t: res_kind expected %0d got %0d", $time, want.kind, m_tdata[1:0]);
                    error_count++;
                end
                if (m_tdata[DW+1:2] !== want.dval) begin
                    $display("%0t: res_dist expected %0d got %0d", $time,
                             $signed(want.dval), $signed(m_tdata[DW+1:2]));
                    error_count++;
                end
                if (m_tdata[DW+3:DW+2] !== want.truth) begin
                    $display("%0t: truth expected %0d got %0d", $time,
                             want.truth, m_tdata[DW+3:DW+2]);
                    error_count++;
                end
                if (m_tdata[DW+4] !== want.ovf) begin
                    $display("%0t: overflow expected %0b got %0b", $time, want.ovf, m_tdata[DW+4]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------ stimulus

    function automatic logic [DW-1:0] pick_dist();
        int     v;
        longint e;
        case ($urandom_range(9))
            0, 1, 2: begin
                v = int'($urandom_range(16)) - 8;
                return v[DW-1:0];
            end
            3: begin
                case ($urandom_range(5))
                    0: e = DIST_MIN;
                    1: e = DIST_MIN + 1;
                    2: e = DIST_MAX;
                    3: e = DIST_MAX - 1;
                    4: e = -1;
                    default: e = 1;
                endcase
                return e[DW-1:0];
            end
            default: return DW'($urandom());
        endcase
    endfunction

    task automatic test_arith_extremes();
        send_item(dda_pkg::OP_ADD, dda_pkg::K_EXACT, DW'(DIST_MAX), dda_pkg::K_EXACT, DW'(1));
        send_item(dda_pkg::OP_SUB, dda_pkg::K_EXACT, DW'(DIST_MIN), dda_pkg::K_EXACT, DW'(1));
        send_item(dda_pkg::OP_SUB, dda_pkg::K_EXACT, DW'(0), dda_pkg::K_EXACT, DW'(DIST_MIN));
        send_item(dda_pkg::OP_MUL, dda_pkg::K_EXACT, DW'(DIST_MIN),
                  dda_pkg::K_EXACT, DW'(DIST_MIN));
        send_item(dda_pkg::OP_NEG, dda_pkg::K_EXACT, DW'(DIST_MIN),
                  dda_pkg::K_UNKNOWN, DW'(DIST_MAX));
        send_item(dda_pkg::OP_NEG, dda_pkg::K_ATLEAST, DW'(5), dda_pkg::K_EXACT, DW'(0));
        // at-most factors flip or keep the bound direction
        send_item(dda_pkg::OP_MUL, dda_pkg::K_ATMOST, DW'(3), dda_pkg::K_ATLEAST, DW'(4));
        send_item(dda_pkg::OP_MUL, dda_pkg::K_ATMOST, DW'(-3), dda_pkg::K_ATMOST, DW'(-4));
        send_item(dda_pkg::OP_MUL, dda_pkg::K_ATLEAST, DW'(2), dda_pkg::K_ATLEAST, DW'(3));
        // exact zero absorbs unknown only from the left
        send_item(dda_pkg::OP_MUL, dda_pkg::K_EXACT, DW'(0), dda_pkg::K_UNKNOWN, DW'(9));
        send_item(dda_pkg::OP_MUL, dda_pkg::K_UNKNOWN, DW'(9), dda_pkg::K_EXACT, DW'(0));
        send_item(dda_pkg::OP_MUL, dda_pkg::K_EXACT, DW'(-2), dda_pkg::K_ATLEAST, DW'(5));
        send_item(dda_pkg::OP_ADD, dda_pkg::K_ATMOST, DW'(5), dda_pkg::K_EXACT, DW'(-3));
        // bound with the wrong sign, used as given
        send_item(dda_pkg::OP_ADD, dda_pkg::K_ATLEAST, DW'(-5), dda_pkg::K_ATLEAST, DW'(2));
    endtask

    task automatic test_compare_cases();
        send_item(dda_pkg::OP_GT, dda_pkg::K_EXACT, DW'(3), dda_pkg::K_ATMOST, DW'(100));
        send_item(dda_pkg::OP_GT, dda_pkg::K_ATLEAST, DW'(10), dda_pkg::K_EXACT, DW'(5));
        send_item(dda_pkg::OP_GE, dda_pkg::K_UNKNOWN, DW'(1), dda_pkg::K_UNKNOWN, DW'(2));
        send_item(dda_pkg::OP_LT, dda_pkg::K_ATMOST, DW'(2), dda_pkg::K_ATLEAST, DW'(5));
        send_item(dda_pkg::OP_LE, dda_pkg::K_EXACT, DW'(7), dda_pkg::K_EXACT, DW'(7));
        send_item(dda_pkg::OP_EQ, dda_pkg::K_ATLEAST, DW'(4), dda_pkg::K_ATLEAST, DW'(4));
        send_item(dda_pkg::OP_NE, dda_pkg::K_UNKNOWN, DW'(0), dda_pkg::K_EXACT, DW'(0));
    endtask

    task automatic test_unused_ops();
        for (int code = dda_pkg::OP_NE + 1; code < 16; code++)
            send_item(dda_pkg::op_t'(code), dda_pkg::K_EXACT, DW'(1), dda_pkg::K_EXACT, DW'(2));
    endtask

    task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
        dda_pkg::op_t   op;
        dda_pkg::kind_t ak;
        dda_pkg::kind_t bk;
        logic [DW-1:0]  ad;
        logic [DW-1:0]  bd;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(19) == 0)
                op = dda_pkg::op_t'($urandom_range(15, dda_pkg::OP_NE + 1));
            else
                op = dda_pkg::op_t'($urandom_range(dda_pkg::OP_NE));
            ak = dda_pkg::kind_t'($urandom_range(3));
            ad = pick_dist();
            // same operands now and then so equality is hit often
            if ($urandom_range(6) == 0) begin
                bk = ak;
                bd = ad;
            end else begin
                bk = dda_pkg::kind_t'($urandom_range(3));
                bd = pick_dist();
            end
            send_item(op, ak, ad, bk, bd);
        end
    endtask

    initial begin
        int drain;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_arith_extremes();
        test_compare_cases();
        test_unused_ops();
        test_random_traffic(475, 0, 0);
        test_random_traffic(475, 46, 0);
        test_random_traffic(475, 0, 46);
        test_random_traffic(475, 27, 27);
        s_tvalid <= 1'b0;

        drain = 0;
        while (pending_results.size() != 0 && drain < 5000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            if (pending_results.size() != 0)
                $display("%0t: %0d results never arrived", $time, pending_results.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
